/* src/bitmap_allocation_map_assert.svh */
`ifndef BITMAP_ALLOCATION_MAP_ASSERT_SVH
`define BITMAP_ALLOCATION_MAP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BAM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bam_pkg.sv */
package bam_pkg;

    localparam int WORD_BITS = 64;
    localparam int OFF_W     = 6;

    localparam logic [2:0] OP_TEST  = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_RANGE = 3'd3;
    localparam logic [2:0] OP_FILL  = 3'd4;
    localparam logic [2:0] OP_FIND  = 3'd5;

    localparam logic [12:0] BITS_IN_USE_RST = 13'd4096;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] bit_index;
        logic [12:0] range_end;
        logic [7:0]  fill_byte;
    } bam_req_t;

    typedef struct packed {
        logic        bit_value;
        logic        found;
        logic [11:0] found_index;
    } bam_rsp_t;

    typedef struct packed {
        logic [2:0]       op;
        logic             first;
        logic             last;
        logic [OFF_W-1:0] lo_off;
        logic [OFF_W-1:0] hi_off;
        logic [7:0]       fill_byte;
    } bam_ctl_t;

    typedef struct packed {
        logic             wr_en;
        word_t            wr_data;
        logic             hit;
        logic [OFF_W-1:0] hit_pos;
        logic             bit_value;
    } bam_upd_t;

endpackage

/* src/bam_word_ram.sv */
module bam_word_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  bam_pkg::word_t      wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output bam_pkg::word_t      rdata
);

    bam_pkg::word_t mem [DEPTH];
    bam_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/bam_word_update.sv */
module bam_word_update (
    input  bam_pkg::bam_ctl_t ctl,
    input  bam_pkg::word_t    rd_data,
    output bam_pkg::bam_upd_t upd
);

    localparam int WB = bam_pkg::WORD_BITS;

    // lowest set bit by halving the window, one step per level
    function automatic logic [bam_pkg::OFF_W-1:0] low_one(input bam_pkg::word_t x);
        bam_pkg::word_t v;
        logic [bam_pkg::OFF_W-1:0] pos;
        v   = x;
        pos = '0;
        for (int k = bam_pkg::OFF_W - 1; k >= 0; k--)
        begin
            if ((v & ((bam_pkg::word_t'(1) << (1 << k)) - bam_pkg::word_t'(1))) == '0)
            begin
                pos[k] = 1'b1;
                v      = v >> (1 << k);
            end
        end
        return pos;
    endfunction

    bam_pkg::word_t lo_mask;
    bam_pkg::word_t hi_mask;
    bam_pkg::word_t mask;
    bam_pkg::word_t one_hot;
    bam_pkg::word_t pattern;
    bam_pkg::word_t cand;

    always_comb
    begin
        lo_mask = ctl.first ? ({WB{1'b1}} << ctl.lo_off) : {WB{1'b1}};
        hi_mask = ctl.last ? ({WB{1'b1}} >> (bam_pkg::OFF_W'(WB - 1) - ctl.hi_off))
                           : {WB{1'b1}};
        mask    = lo_mask & hi_mask;
        one_hot = bam_pkg::word_t'(1) << ctl.lo_off;
        pattern = {(WB / 8){ctl.fill_byte}};
        cand    = ~rd_data & mask;

        upd.wr_en     = 1'b0;
        upd.wr_data   = rd_data;
        upd.hit       = 1'b0;
        upd.hit_pos   = low_one(cand);
        upd.bit_value = 1'b0;

        unique case (ctl.op)
            bam_pkg::OP_TEST:
            begin
                upd.bit_value = rd_data[ctl.lo_off];
            end
            bam_pkg::OP_SET:
            begin
                upd.wr_en   = 1'b1;
                upd.wr_data = rd_data | one_hot;
            end
            bam_pkg::OP_CLEAR:
            begin
                upd.wr_en   = 1'b1;
                upd.wr_data = rd_data & ~one_hot;
            end
            bam_pkg::OP_RANGE:
            begin
                upd.wr_en   = 1'b1;
                upd.wr_data = rd_data & ~mask;
            end
            bam_pkg::OP_FILL:
            begin
                upd.wr_en   = 1'b1;
                upd.wr_data = pattern & hi_mask;
            end
            bam_pkg::OP_FIND:
            begin
                upd.hit = (cand != '0);
            end
            default:
            begin
                upd.wr_en = 1'b0;
            end
        endcase
    end

endmodule

/* src/bitmap_allocation_map.sv */
// bitmap allocator with find-first-zero, state held in one word memory
// request channel: a transaction is taken at a clock edge with start high and
//   busy low; req carries the request type, bit index, range end and fill byte
// result channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot stall, every request gives exactly one result
// config: cfg_we writes cfg_wdata into bits_in_use; the user must write it only
//   while the block is idle, which the block itself does not enforce
// sequencing: a request that touches no word answers in the next cycle; otherwise
//   words first..last are read one per cycle through the memory read port and,
//   for set, clear, range and fill, written back in the cycle after; a find stops
//   at the first word with a free bit in range; the result goes out with that word
// occupancy: a walk takes the words in turn through the single read and write
//   port of the memory, and busy stays high until the result is issued
// reset: the map is cleared by a pass that writes zero to every word, during which
//   busy is high; bits_in_use returns to 4096
`include "bitmap_allocation_map_assert.svh"

module bitmap_allocation_map #(
    parameter int TOTAL_BITS = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bam_pkg::bam_req_t req,
    output logic              done,
    output bam_pkg::bam_rsp_t rsp,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_wdata
);

    localparam int WB        = bam_pkg::WORD_BITS;
    localparam int OW        = bam_pkg::OFF_W;
    localparam int NUM_WORDS = (TOTAL_BITS + WB - 1) / WB;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IW        = ($clog2(TOTAL_BITS + 1) > 13) ? $clog2(TOTAL_BITS + 1) : 13;

    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [IW-1:0] TOTAL_W   = IW'(TOTAL_BITS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     last_reg, last_next;
    logic              first_pend_reg, first_pend_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_first_reg, s1_first_next;
    logic              s1_last_reg, s1_last_next;
    logic [AW-1:0]     s1_word_reg, s1_word_next;
    logic              done_reg, done_next;
    logic [12:0]       bits_in_use_reg;
    logic [2:0]        op_reg, op_next;
    logic [OW-1:0]     lo_reg, lo_next;
    logic [OW-1:0]     hi_reg, hi_next;
    logic [7:0]        pat_reg, pat_next;
    bam_pkg::bam_rsp_t rsp_reg, rsp_next;

    logic [IW-1:0]     idx_w, end_w, end_c, em1, n_w, n_c, nm1, fi_w;
    logic              go;
    logic [AW-1:0]     first_w, last_w;
    logic [OW-1:0]     lo_w, hi_w;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr;
    bam_pkg::word_t    mem_wdata, mem_rdata;
    bam_pkg::bam_ctl_t ctl;
    bam_pkg::bam_upd_t upd;

    // request decode: word span and edge offsets
    always_comb
    begin
        idx_w = IW'(req.bit_index);
        end_w = IW'(req.range_end);
        n_w   = IW'(bits_in_use_reg);
        end_c = (end_w > TOTAL_W) ? TOTAL_W : end_w;
        n_c   = (n_w > TOTAL_W) ? TOTAL_W : n_w;
        em1   = end_c - IW'(1);
        nm1   = n_c - IW'(1);

        go      = 1'b0;
        first_w = idx_w[AW+OW-1:OW];
        last_w  = idx_w[AW+OW-1:OW];
        lo_w    = idx_w[OW-1:0];
        hi_w    = idx_w[OW-1:0];

        unique case (req.req_type)
            bam_pkg::OP_TEST, bam_pkg::OP_SET, bam_pkg::OP_CLEAR:
            begin
                go = (idx_w < TOTAL_W);
            end
            bam_pkg::OP_RANGE:
            begin
                go     = (idx_w < end_c);
                last_w = em1[AW+OW-1:OW];
                hi_w   = em1[OW-1:0];
            end
            bam_pkg::OP_FILL:
            begin
                go      = (n_c != '0);
                first_w = '0;
                lo_w    = '0;
                last_w  = nm1[AW+OW-1:OW];
                hi_w    = nm1[OW-1:0];
            end
            bam_pkg::OP_FIND:
            begin
                go     = (idx_w < n_c);
                last_w = nm1[AW+OW-1:OW];
                hi_w   = nm1[OW-1:0];
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
    end

    assign ctl.op        = op_reg;
    assign ctl.first     = s1_first_reg;
    assign ctl.last      = s1_last_reg;
    assign ctl.lo_off    = lo_reg;
    assign ctl.hi_off    = hi_reg;
    assign ctl.fill_byte = pat_reg;

    bam_word_update u_update (
        .ctl     (ctl),
        .rd_data (mem_rdata),
        .upd     (upd)
    );

    assign fi_w = IW'({s1_word_reg, upd.hit_pos});

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        last_next       = last_reg;
        first_pend_next = first_pend_reg;
        s1_valid_next   = 1'b0;
        s1_first_next   = s1_first_reg;
        s1_last_next    = s1_last_reg;
        s1_word_next    = s1_word_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pat_next        = pat_reg;
        rsp_next        = rsp_reg;
        mem_re          = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = req.req_type;
                    lo_next  = lo_w;
                    hi_next  = hi_w;
                    pat_next = req.fill_byte;
                    if (go)
                    begin
                        state_next      = ST_RUN;
                        ptr_next        = first_w;
                        last_next       = last_w;
                        first_pend_next = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                end
            end
            ST_RUN:
            begin
                mem_re          = 1'b1;
                s1_valid_next   = 1'b1;
                s1_first_next   = first_pend_reg;
                s1_last_next    = (ptr_reg == last_reg);
                s1_word_next    = ptr_reg;
                first_pend_next = 1'b0;
                ptr_next        = ptr_reg + AW'(1);
                if (ptr_reg == last_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_WAIT;
            end
        endcase

        // last word processed or search hit ends the transaction
        if (s1_valid_reg && (s1_last_reg || upd.hit))
        begin
            state_next            = ST_IDLE;
            s1_valid_next         = 1'b0;
            done_next             = 1'b1;
            rsp_next.bit_value    = upd.bit_value;
            rsp_next.found        = upd.hit;
            rsp_next.found_index  = upd.hit ? fi_w[11:0] : 12'd0;
        end
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (s1_valid_reg && upd.wr_en);
    assign mem_waddr = (state_reg == ST_CLEAR) ? ptr_reg : s1_word_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : upd.wr_data;

    bam_word_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            ptr_reg         <= '0;
            last_reg        <= '0;
            first_pend_reg  <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_first_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
            s1_word_reg     <= '0;
            done_reg        <= 1'b0;
            bits_in_use_reg <= bam_pkg::BITS_IN_USE_RST;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            last_reg       <= last_next;
            first_pend_reg <= first_pend_next;
            s1_valid_reg   <= s1_valid_next;
            s1_first_reg   <= s1_first_next;
            s1_last_reg    <= s1_last_next;
            s1_word_reg    <= s1_word_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                bits_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        pat_reg <= pat_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `BAM_ASSERT_NOW(a_done_idle, done_reg, !busy, "result issued while busy")
    `BAM_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_reg,
        "accepted transaction neither started nor answered")
    `BAM_ASSERT_NOW(a_write_busy, mem_we, busy, "memory write while idle")
    `BAM_ASSERT_NOW(a_stage_state, s1_valid_reg,
        (state_reg == ST_RUN) || (state_reg == ST_WAIT), "word in flight outside a walk")

endmodule
